/* hdl/assert_macros.svh */
// assertion macros shared by the rtl files
// every macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hdl/tdp_pkg.sv */
// shared constants and types for the trial division prime test
// no dependencies
`default_nettype none

package tdp_pkg;

    localparam int DATA_WIDTH = 31;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        data_t quotient;
        data_t remainder;
    } div_result_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* hdl/tdp_serial_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on tdp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tdp_serial_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire tdp_pkg::data_t     dividend,
    input  wire tdp_pkg::data_t     divisor,
    output logic                    done,
    output tdp_pkg::div_result_t    result
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [tdp_pkg::CNT_W-1:0] count_reg, count_next;
    tdp_pkg::data_t          quo_reg, quo_next;
    tdp_pkg::data_t          rem_reg, rem_next;

    logic [tdp_pkg::DATA_WIDTH:0] trial;
    logic [tdp_pkg::DATA_WIDTH:0] diff;
    logic                         fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[tdp_pkg::DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    // trial stays below twice the divisor, so a borrow shows in the top bit
    assign fits  = ~diff[tdp_pkg::DATA_WIDTH];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = tdp_pkg::CNT_W'(tdp_pkg::DATA_WIDTH);
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[tdp_pkg::DATA_WIDTH-2:0], fits};
            rem_next   = fits ? diff[tdp_pkg::DATA_WIDTH-1:0]
                              : trial[tdp_pkg::DATA_WIDTH-1:0];
            count_next = count_reg - tdp_pkg::CNT_W'(1);
            if (count_reg == tdp_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

    `ASSERT_NEVER(a_done_while_busy, done_reg && busy_reg, "done raised during division")
    `ASSERT_NEVER(a_start_while_busy, start && busy_reg, "division restarted while busy")
    `ASSERT_CLK(a_rem_below_divisor, done_reg |-> (rem_reg < divisor),
        "remainder not below divisor")

endmodule

`default_nettype wire

/* hdl/trial_division_prime_test.sv */
// top level of the trial division prime test: sequencer and output register
// depends on tdp_pkg, tdp_serial_div and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

// Tests one unsigned candidate at a time for primality by trial division
// with divisors 2, 3, 4, ... until the quotient drops below the divisor
// (prime) or a remainder is zero (composite); candidates 0 and 1 skip the
// divider and pass from the idle state through the finish state to the
// output register. Each trial divisor runs through the radix-2 serial
// divider that produces one quotient bit per cycle, and a composite stops
// at its smallest factor. A finished result sits in an output register,
// so the next candidate is taken while the previous result waits on
// result_ready.
module trial_division_prime_test (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tdp_pkg::DATA_WIDTH-1:0] candidate,
    input  wire logic                          candidate_valid,
    output logic                               candidate_ready,
    output logic                               prime_flag,
    output logic                               result_valid,
    input  wire logic                          result_ready
);

    tdp_pkg::state_t      state_reg, state_next;
    tdp_pkg::data_t       cand_reg, cand_next;
    tdp_pkg::data_t       divisor_reg, divisor_next;
    logic                 flag_reg, flag_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_flag_reg, out_flag_next;
    logic                 div_start;
    logic                 div_done;
    tdp_pkg::div_result_t div_result;

    tdp_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .result   (div_result)
    );

    assign candidate_ready = (state_reg == tdp_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        divisor_next   = divisor_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_flag_next  = out_flag_reg;
        div_start      = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tdp_pkg::S_IDLE:
            begin
                if (candidate_valid)
                begin
                    cand_next    = candidate;
                    divisor_next = tdp_pkg::DATA_WIDTH'(2);
                    if (candidate[tdp_pkg::DATA_WIDTH-1:1] == '0)
                    begin
                        // zero and one are not prime
                        flag_next  = 1'b0;
                        state_next = tdp_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = tdp_pkg::S_START;
                    end
                end
            end
            tdp_pkg::S_START:
            begin
                div_start  = 1'b1;
                state_next = tdp_pkg::S_WAIT;
            end
            tdp_pkg::S_WAIT:
            begin
                if (div_done)
                begin
                    if (div_result.quotient < divisor_reg)
                    begin
                        flag_next  = 1'b1;
                        state_next = tdp_pkg::S_FINISH;
                    end
                    else if (div_result.remainder == '0)
                    begin
                        flag_next  = 1'b0;
                        state_next = tdp_pkg::S_FINISH;
                    end
                    else
                    begin
                        divisor_next = divisor_reg + tdp_pkg::DATA_WIDTH'(1);
                        state_next   = tdp_pkg::S_START;
                    end
                end
            end
            tdp_pkg::S_FINISH:
            begin
                // load only when the output slot is free or being drained
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = flag_reg;
                    state_next     = tdp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        divisor_reg  <= divisor_next;
        flag_reg     <= flag_next;
        out_flag_reg <= out_flag_next;
    end

    assign prime_flag   = out_flag_reg;
    assign result_valid = out_valid_reg;

    `ASSERT_CLK(a_divisor_min, (state_reg == tdp_pkg::S_WAIT) |->
        (divisor_reg[tdp_pkg::DATA_WIDTH-1:1] != '0), "trial divisor below two")
    `ASSERT_CLK(a_start_from_start_state, div_start |=>
        (state_reg == tdp_pkg::S_WAIT), "divider started outside start state")
    `ASSERT_CLK(a_result_held, (result_valid && !result_ready) |=>
        (result_valid && $stable(prime_flag)), "waiting result dropped or changed")

endmodule

`default_nettype wire
